// File: src/assert_macros.svh
// Assertion macros used by the top level of the sprite animator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, off while reset is low
`define SFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define SFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error(msg);

`endif

// File: src/sfa_pkg.sv
// Types, codes and helper functions of the sprite frame animator
`default_nettype none

package sfa_pkg;

    localparam int MAX_SIDE_DEF   = 64;
    localparam int MAX_FRAMES_DEF = 255;

    // frame advance remainder unit: one dividend bit per cycle
    localparam int DIV_W     = 9;
    localparam int DIV_CNT_W = 4;
    // r_settle value at which frame_base is valid after a frame or geometry change
    localparam int BASE_LAT  = 2;

    localparam logic [1:0] ACT_BEGIN  = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_PIXEL  = 2'd2;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_FETCH = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;

    localparam logic [2:0] REG_POS_X       = 3'd0;
    localparam logic [2:0] REG_POS_Y       = 3'd1;
    localparam logic [2:0] REG_PIXEL_SCALE = 3'd2;
    localparam logic [2:0] REG_SPRITE_W    = 3'd3;
    localparam logic [2:0] REG_SPRITE_H    = 3'd4;
    localparam logic [2:0] REG_FRAME_TOTAL = 3'd5;
    localparam logic [2:0] REG_INTERVAL    = 3'd6;
    localparam logic [2:0] REG_COLOR_KEY   = 3'd7;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic [15:0] pixel_color;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] rect_x;
        logic [11:0] rect_y;
        logic [9:0]  rect_w;
        logic [9:0]  rect_h;
        logic [15:0] fill_color;
        logic [7:0]  frame_number;
        logic [19:0] frame_base;
        logic        last;
    } t_out;

    typedef struct packed {
        logic begin_anim;
        logic update;
        logic pixel;
        logic div_step;
        logic load_clr;
        logic load_fetch;
    } t_cmd;

    typedef struct packed {
        logic due;
        logic base_ok;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic logic [6:0] eff_side(input logic [6:0] v, input int max_side);
        logic [6:0] r;
        if (v == 7'd0) begin
            r = 7'd1;
        end else if (int'(v) > max_side) begin
            r = 7'(max_side);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [7:0] eff_frames(input logic [7:0] v, input int max_frames);
        logic [7:0] r;
        if (v == 8'd0) begin
            r = 8'd1;
        end else if (int'(v) > max_frames) begin
            r = 8'(max_frames);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [9:0] sat10(input logic [10:0] v);
        return (v > 11'd1023) ? 10'd1023 : v[9:0];
    endfunction

endpackage

`default_nettype wire

// File: src/sfa_ctrl.sv
// Controller state machine of the sprite frame animator
`default_nettype none

module sfa_ctrl import sfa_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_action,
    input  wire t_sts       i_sts,
    output logic            o_in_stall,
    output t_cmd            o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_CLEAR = 4'b0100,
        S_FETCH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = !((r_state == S_IDLE) && i_sts.base_ok && i_sts.out_free);
        accept     = i_in_valid && !o_in_stall;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_BEGIN: begin
                            o_cmd.begin_anim = 1'b1;
                            n_state          = S_FETCH;
                        end
                        ACT_UPDATE: begin
                            if (i_sts.due) begin
                                o_cmd.update = 1'b1;
                                n_state      = S_DIV;
                            end
                        end
                        ACT_PIXEL: begin
                            o_cmd.pixel = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (i_sts.base_ok && i_sts.out_free) begin
                    o_cmd.load_clr = 1'b1;
                    n_state        = S_FETCH;
                end
            end
            S_FETCH: begin
                if (i_sts.base_ok && i_sts.out_free) begin
                    o_cmd.load_fetch = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: src/sfa_dp.sv
// Datapath: registers, timer check, frame remainder unit, raster and result register
`default_nettype none

module sfa_dp import sfa_pkg::*; #(
    parameter int MAX_SIDE   = MAX_SIDE_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_in         i_in,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_out_valid,
    output t_out             o_out_data,
    input  wire logic        i_out_stall
);

    localparam int CNT_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CW    = (CNT_W + 1 > 7) ? CNT_W + 1 : 7;

    logic [10:0] r_pos_x, r_pos_y;
    logic [3:0]  r_scale;
    logic [6:0]  r_sprite_w, r_sprite_h;
    logic [7:0]  r_frame_total;
    logic [15:0] r_interval;
    logic [15:0] r_color_key;

    logic [31:0] r_last_time;
    logic [7:0]  r_cur;
    logic [CNT_W-1:0] r_row, r_col;
    logic        r_drawing;

    logic [DIV_W-1:0]     r_dvd, r_rem;
    logic [DIV_CNT_W-1:0] r_dcnt;

    logic [14:0] r_fw;
    logic [19:0] r_base;
    logic [1:0]  r_settle;

    logic        r_out_valid;
    t_out        r_out;

    logic [6:0]  eff_w, eff_h;
    logic [7:0]  eff_f;
    logic [31:0] elapsed;
    logic [DIV_W-1:0] rem_sh, n_rem;
    logic [CW-1:0] col_nx, row_nx;
    logic        col_end, row_end;
    logic        keyed;
    logic [11:0] fill_x, fill_y;
    logic        out_free;
    logic        n_out_load;
    t_out        n_out;

    assign eff_w = eff_side(r_sprite_w, MAX_SIDE);
    assign eff_h = eff_side(r_sprite_h, MAX_SIDE);
    assign eff_f = eff_frames(r_frame_total, MAX_FRAMES);

    assign elapsed = i_in.now_ms - r_last_time;

    // restoring remainder: shift in one dividend bit, subtract frame count if it fits
    assign rem_sh = {r_rem[DIV_W-2:0], r_dvd[DIV_W-1]};
    assign n_rem  = (rem_sh >= DIV_W'(eff_f)) ? rem_sh - DIV_W'(eff_f) : rem_sh;

    assign col_nx  = CW'(r_col) + CW'(1);
    assign row_nx  = CW'(r_row) + CW'(1);
    assign col_end = col_nx >= CW'(eff_w);
    assign row_end = row_nx >= CW'(eff_h);
    assign keyed   = i_in.pixel_color == r_color_key;

    assign fill_x = 12'(r_pos_x) + 12'(r_col) * 12'(r_scale);
    assign fill_y = 12'(r_pos_y) + 12'(r_row) * 12'(r_scale);

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts.due      = elapsed >= 32'(r_interval);
        o_sts.base_ok  = r_settle == 2'(BASE_LAT);
        o_sts.div_done = r_dcnt == DIV_CNT_W'(DIV_W - 1);
        o_sts.out_free = out_free;
    end

    always_comb begin
        n_out              = '0;
        n_out.frame_number = r_cur;
        n_out.frame_base   = r_base;
        n_out_load         = 1'b0;
        if (i_cmd.load_clr) begin
            n_out.kind   = KIND_CLEAR;
            n_out.rect_x = 12'(r_pos_x);
            n_out.rect_y = 12'(r_pos_y);
            n_out.rect_w = sat10(11'(eff_w) * 11'(r_scale));
            n_out.rect_h = sat10(11'(eff_h) * 11'(r_scale));
            n_out_load   = 1'b1;
        end else if (i_cmd.load_fetch) begin
            n_out.kind = KIND_FETCH;
            n_out.last = 1'b1;
            n_out_load = 1'b1;
        end else if (i_cmd.pixel && r_drawing && !keyed) begin
            n_out.kind       = KIND_FILL;
            n_out.rect_x     = fill_x;
            n_out.rect_y     = fill_y;
            n_out.rect_w     = 10'(r_scale);
            n_out.rect_h     = 10'(r_scale);
            n_out.fill_color = i_in.pixel_color;
            n_out.last       = 1'b1;
            n_out_load       = 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x       <= 11'd0;
            r_pos_y       <= 11'd0;
            r_scale       <= 4'd1;
            r_sprite_w    <= 7'd20;
            r_sprite_h    <= 7'd20;
            r_frame_total <= 8'd1;
            r_interval    <= 16'd100;
            r_color_key   <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POS_X:       r_pos_x       <= i_cfg_data[10:0];
                REG_POS_Y:       r_pos_y       <= i_cfg_data[10:0];
                REG_PIXEL_SCALE: r_scale       <= i_cfg_data[3:0];
                REG_SPRITE_W:    r_sprite_w    <= i_cfg_data[6:0];
                REG_SPRITE_H:    r_sprite_h    <= i_cfg_data[6:0];
                REG_FRAME_TOTAL: r_frame_total <= i_cfg_data[7:0];
                REG_INTERVAL:    r_interval    <= i_cfg_data;
                REG_COLOR_KEY:   r_color_key   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // animation state, raster and remainder unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= 32'd0;
            r_cur       <= 8'd0;
            r_row       <= '0;
            r_col       <= '0;
            r_drawing   <= 1'b0;
            r_dcnt      <= '0;
        end else begin
            if (i_cmd.begin_anim || i_cmd.update) begin
                r_last_time <= i_in.now_ms;
                r_row       <= '0;
                r_col       <= '0;
                r_drawing   <= 1'b1;
            end else if (i_cmd.pixel && r_drawing) begin
                if (col_end) begin
                    r_col <= '0;
                    if (row_end) begin
                        r_row     <= '0;
                        r_drawing <= 1'b0;
                    end else begin
                        r_row <= CNT_W'(row_nx);
                    end
                end else begin
                    r_col <= CNT_W'(col_nx);
                end
            end
            if (i_cmd.begin_anim) begin
                r_cur <= 8'd0;
            end
            if (i_cmd.update) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + DIV_CNT_W'(1);
                if (o_sts.div_done) begin
                    r_cur <= n_rem[7:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_dvd <= DIV_W'(r_cur) + DIV_W'(1);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    // frame_base = frame * width * height, two registered products
    always_ff @(posedge i_clk) begin
        r_fw   <= 15'(r_cur) * 15'(eff_w);
        r_base <= 20'(22'(r_fw) * 22'(eff_h));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= 2'd0;
        end else if (i_cfg_we || i_cmd.begin_anim || (i_cmd.div_step && o_sts.div_done)) begin
            r_settle <= 2'd0;
        end else if (r_settle != 2'(BASE_LAT)) begin
            r_settle <= r_settle + 2'd1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: src/sprite_frame_animator.sv
// Top level of the sprite frame animator: controller plus datapath
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | in        | i_in_valid / o_in_stall   | i_in_data  (t_in)
//  out     | out       | o_out_valid / i_out_stall | o_out_data (t_out)
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Pixel items and updates that are not yet due are taken without leaving the idle state.
// A due update runs the bit-serial frame remainder, waits on the frame_base multiplier
// pipeline, then issues the clear and fetch requests.
// A begin item waits on the same multiplier pipeline, then issues the fetch request.
// After reset or a config write, input is held off while frame_base settles.
// One result register; a stalled output blocks new input only once it is full.
`default_nettype none

`include "assert_macros.svh"

module sprite_frame_animator import sfa_pkg::*; #(
    parameter int MAX_SIDE   = MAX_SIDE_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    sfa_dp #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    `SFA_ASSERT(a_load_free, (cmd.load_clr || cmd.load_fetch) |-> sts.out_free, "result overrun")
    `SFA_ASSERT(a_busy_in_div, cmd.div_step |-> o_in_stall, "input taken during frame advance")
    `SFA_ASSERT_NEXT(a_begin_base_stale, cmd.begin_anim, !sts.base_ok, "stale frame_base")

endmodule

`default_nettype wire

// File: tb/tb_sprite_frame_animator.sv
// Testbench for sprite_frame_animator: directed and random animation traffic with a predictor
`timescale 1ns / 100ps

module tb_sprite_frame_animator;
    import sfa_pkg::*;

    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         QUIET_LIMIT   = 5000;
    localparam int         SEG_ITEMS     = 135;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in         in_data = '0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_POS_X;
    logic [15:0] cfg_data = '0;

    // register copies, reset values
    logic [10:0] cfg_pos_x = '0;
    logic [10:0] cfg_pos_y = '0;
    logic [3:0]  cfg_scale = 4'd1;
    logic [6:0]  cfg_w = 7'd20;
    logic [6:0]  cfg_h = 7'd20;
    logic [7:0]  cfg_frames = 8'd1;
    logic [15:0] cfg_interval = 16'd100;
    logic [15:0] cfg_key = '0;

    // animation state
    logic [31:0] st_last_time = '0;
    logic [7:0]  st_frame = '0;
    logic [5:0]  st_row = '0;
    logic [5:0]  st_col = '0;
    logic        st_drawing = 1'b0;

    t_out pending_draws[$];
    int   mismatch_count = 0;
    int   sent_items = 0;
    int   quiet_cycles = 0;
    int   src_idle_pct = 0;
    int   rcv_stall_pct = 0;

    sprite_frame_animator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    function automatic int side_eff(input logic [6:0] v);
        if (v == 7'd0) return 1;
        if (int'(v) > MAX_SIDE_DEF) return MAX_SIDE_DEF;
        return int'(v);
    endfunction

    function automatic t_out draw_req(input logic [1:0] kind, input int x, input int y,
                                      input int w, input int h, input logic [15:0] color,
                                      input bit fin);
        t_out r;
        r.kind         = kind;
        r.rect_x       = 12'(x);
        r.rect_y       = 12'(y);
        r.rect_w       = 10'(w);
        r.rect_h       = 10'(h);
        r.fill_color   = color;
        r.frame_number = st_frame;
        r.frame_base   = 20'(int'(st_frame) * side_eff(cfg_w) * side_eff(cfg_h));
        r.last         = fin;
        return r;
    endfunction

    // Advances the animation state for one accepted request and queues the draw
    // requests it causes. Returns 1 unless the request was ignored.
    function automatic bit animate_step(input t_in req);
        int w, h, nf, box_w, box_h;
        logic [31:0] elapsed;
        w = side_eff(cfg_w);
        h = side_eff(cfg_h);
        case (req.action)
            ACT_BEGIN: begin
                st_frame     = '0;
                st_last_time = req.now_ms;
                st_row       = '0;
                st_col       = '0;
                st_drawing   = 1'b1;
                pending_draws.push_back(draw_req(KIND_FETCH, 0, 0, 0, 0, 16'd0, 1'b1));
                return 1'b1;
            end
            ACT_UPDATE: begin
                elapsed = req.now_ms - st_last_time;
                if (elapsed < {16'd0, cfg_interval}) return 1'b0;
                nf = (cfg_frames == 8'd0) ? 1 : int'(cfg_frames);
                if (nf > MAX_FRAMES_DEF) nf = MAX_FRAMES_DEF;
                st_last_time = req.now_ms;
                st_frame     = 8'((int'(st_frame) + 1) % nf);
                st_row       = '0;
                st_col       = '0;
                st_drawing   = 1'b1;
                box_w = w * int'(cfg_scale);
                box_h = h * int'(cfg_scale);
                if (box_w > 1023) box_w = 1023;
                if (box_h > 1023) box_h = 1023;
                pending_draws.push_back(draw_req(KIND_CLEAR, int'(cfg_pos_x), int'(cfg_pos_y),
                                                 box_w, box_h, 16'd0, 1'b0));
                pending_draws.push_back(draw_req(KIND_FETCH, 0, 0, 0, 0, 16'd0, 1'b1));
                return 1'b1;
            end
            ACT_PIXEL: begin
                if (!st_drawing) return 1'b0;
                if (req.pixel_color != cfg_key) begin
                    pending_draws.push_back(draw_req(KIND_FILL,
                        int'(cfg_pos_x) + int'(st_col) * int'(cfg_scale),
                        int'(cfg_pos_y) + int'(st_row) * int'(cfg_scale),
                        int'(cfg_scale), int'(cfg_scale), req.pixel_color, 1'b1));
                end
                if (int'(st_col) + 1 >= w) begin
                    st_col = '0;
                    if (int'(st_row) + 1 >= h) begin
                        st_row     = '0;
                        st_drawing = 1'b0;
                    end else begin
                        st_row = st_row + 6'd1;
                    end
                end else begin
                    st_col = st_col + 6'd1;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Call at a falling edge; returns at the falling edge after acceptance
    task automatic send_action(input logic [1:0] act, input logic [31:0] now,
                               input logic [15:0] color);
        t_in req;
        req.action      = act;
        req.now_ms      = now;
        req.pixel_color = color;
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        void'(animate_step(req));
        sent_items++;
        @(negedge clk);
    endtask

    // Hold off input until every expected request is back, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_draws.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_POS_X:       cfg_pos_x    = data[10:0];
            REG_POS_Y:       cfg_pos_y    = data[10:0];
            REG_PIXEL_SCALE: cfg_scale    = data[3:0];
            REG_SPRITE_W:    cfg_w        = data[6:0];
            REG_SPRITE_H:    cfg_h        = data[6:0];
            REG_FRAME_TOTAL: cfg_frames   = data[7:0];
            REG_INTERVAL:    cfg_interval = data;
            REG_COLOR_KEY:   cfg_key      = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Sometimes sets the bits above the register width, which must be dropped
    function automatic logic [15:0] cfg_word(input int v, input int width);
        logic [15:0] mask;
        mask = 16'((1 << width) - 1);
        if ($urandom_range(3) == 0) return 16'(v) | (16'($urandom) & ~mask);
        return 16'(v);
    endfunction

    function automatic int pick_side();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 64;
            2:       return $urandom_range(65, 127);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic int pick_pos();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 2047;
            default: return $urandom_range(2047);
        endcase
    endfunction

    // Update times clustered around the due threshold
    function automatic logic [31:0] update_time();
        logic [31:0] gap;
        case ($urandom_range(5))
            0:       gap = {16'd0, cfg_interval};
            1:       gap = (cfg_interval == 16'd0) ? 32'd0 : {16'd0, cfg_interval} - 32'd1;
            2:       gap = $urandom;
            3:       gap = {16'd0, cfg_interval} + $urandom_range(3);
            default: gap = $urandom_range({16'd0, cfg_interval});
        endcase
        return st_last_time + gap;
    endfunction

    // Rest of the current frame when short, else a slice of it; stray pixels when idle
    task automatic pixel_burst(input int max_n);
        int rem, n, i;
        rem = side_eff(cfg_w) * side_eff(cfg_h)
              - (int'(st_row) * side_eff(cfg_w) + int'(st_col));
        if (!st_drawing) rem = $urandom_range(1, 3);
        n = (rem <= max_n) ? rem : $urandom_range(1, max_n);
        for (i = 0; i < n; i++) begin
            send_action(ACT_PIXEL, $urandom,
                        ($urandom_range(9) < 3) ? cfg_key : 16'($urandom));
        end
    endtask

    task automatic test_ignored_items();
        send_action(ACT_PIXEL, 32'd0, 16'h5555);
        send_action(ACT_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        send_action(ACT_UPDATE, 32'd99, 16'd0);
        send_action(ACT_UPDATE, 32'd100, 16'd0);
    endtask

    task automatic test_keyed_scaled_frame();
        wait_drained();
        write_reg(REG_POS_X, 16'd2047);
        write_reg(REG_POS_Y, 16'd2047);
        write_reg(REG_PIXEL_SCALE, 16'd15);
        write_reg(REG_SPRITE_W, 16'd2);
        write_reg(REG_SPRITE_H, 16'd2);
        write_reg(REG_FRAME_TOTAL, 16'd3);
        write_reg(REG_INTERVAL, 16'hFFFF);
        write_reg(REG_COLOR_KEY, 16'hFFFF);
        send_action(ACT_BEGIN, 32'hFFFF_FFFF, 16'd0);
        send_action(ACT_PIXEL, 32'd0, 16'h0000);
        send_action(ACT_PIXEL, 32'd0, 16'hFFFF);
        send_action(ACT_PIXEL, 32'd0, 16'hFFFE);
        send_action(ACT_PIXEL, 32'd0, 16'h8001);
        send_action(ACT_PIXEL, 32'd0, 16'h1234);
    endtask

    task automatic test_frame_timing();
        // elapsed wraps through zero
        send_action(ACT_UPDATE, 32'd65533, 16'd0);
        send_action(ACT_UPDATE, 32'd65534, 16'd0);
        send_action(ACT_PIXEL, 32'd0, 16'h0001);
        send_action(ACT_UPDATE, 32'd131069, 16'd0);
        send_action(ACT_PIXEL, 32'd0, 16'h0002);
        send_action(ACT_BEGIN, 32'd0, 16'd0);
        wait_drained();
        write_reg(REG_INTERVAL, 16'd0);
        repeat (3) send_action(ACT_UPDATE, 32'd0, 16'd0);
    endtask

    task automatic test_dimension_clamps();
        wait_drained();
        write_reg(REG_SPRITE_W, 16'd0);
        write_reg(REG_SPRITE_H, 16'd100);
        write_reg(REG_PIXEL_SCALE, 16'd0);
        write_reg(REG_FRAME_TOTAL, 16'd0);
        write_reg(REG_POS_X, 16'd0);
        write_reg(REG_POS_Y, 16'd0);
        write_reg(REG_COLOR_KEY, 16'd0);
        send_action(ACT_BEGIN, 32'h8000_0000, 16'd0);
        send_action(ACT_PIXEL, 32'd0, 16'h0000);
        send_action(ACT_PIXEL, 32'd0, 16'hFFFF);
        send_action(ACT_UPDATE, 32'h8000_0000, 16'd0);
        wait_drained();
        write_reg(REG_SPRITE_W, 16'd127);
        write_reg(REG_PIXEL_SCALE, 16'd15);
        write_reg(REG_FRAME_TOTAL, 16'd255);
        write_reg(REG_POS_Y, 16'd2047);
        send_action(ACT_BEGIN, 32'd5, 16'd0);
        send_action(ACT_UPDATE, 32'd5, 16'd0);
        send_action(ACT_PIXEL, 32'd0, 16'h1234);
    endtask

    task automatic test_random_animation();
        int phase, seg, seg_start, pick;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 12; rcv_stall_pct = 55; end
                1:       begin src_idle_pct = 55; rcv_stall_pct = 12; end
                default: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
            endcase
            for (seg = 0; seg < 4; seg++) begin
                wait_drained();
                write_reg(REG_POS_X, cfg_word(pick_pos(), 11));
                write_reg(REG_POS_Y, cfg_word(pick_pos(), 11));
                write_reg(REG_PIXEL_SCALE, cfg_word($urandom_range(15), 4));
                write_reg(REG_SPRITE_W, cfg_word(pick_side(), 7));
                write_reg(REG_SPRITE_H, cfg_word(pick_side(), 7));
                case ($urandom_range(9))
                    0:       write_reg(REG_FRAME_TOTAL, cfg_word(0, 8));
                    1:       write_reg(REG_FRAME_TOTAL, cfg_word(255, 8));
                    2:       write_reg(REG_FRAME_TOTAL, cfg_word($urandom_range(255), 8));
                    default: write_reg(REG_FRAME_TOTAL, cfg_word($urandom_range(1, 5), 8));
                endcase
                case ($urandom_range(9))
                    0:       write_reg(REG_INTERVAL, 16'd0);
                    1:       write_reg(REG_INTERVAL, 16'hFFFF);
                    2:       write_reg(REG_INTERVAL, 16'($urandom));
                    default: write_reg(REG_INTERVAL, 16'($urandom_range(30)));
                endcase
                write_reg(REG_COLOR_KEY, 16'($urandom));
                seg_start = sent_items;
                while (sent_items - seg_start < SEG_ITEMS) begin
                    pick = $urandom_range(99);
                    if (pick < 2) begin
                        wait_drained();
                    end else if (pick < 22) begin
                        send_action(ACT_BEGIN, $urandom, 16'($urandom));
                        if ($urandom_range(9) < 8) pixel_burst(64);
                    end else if (pick < 47) begin
                        send_action(ACT_UPDATE, update_time(), 16'($urandom));
                        if ($urandom_range(9) < 8) pixel_burst(64);
                    end else if (pick < 92) begin
                        pixel_burst(64);
                    end else begin
                        send_action(ACT_UNUSED, $urandom, 16'($urandom));
                    end
                end
            end
        end
    endtask

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_draws.size() == 0) begin
                report_mismatch($sformatf("unexpected request kind %0d", out_data.kind));
            end else begin
                want = pending_draws.pop_front();
                check_field("kind", 32'(out_data.kind), 32'(want.kind));
                check_field("rect_x", 32'(out_data.rect_x), 32'(want.rect_x));
                check_field("rect_y", 32'(out_data.rect_y), 32'(want.rect_y));
                check_field("rect_w", 32'(out_data.rect_w), 32'(want.rect_w));
                check_field("rect_h", 32'(out_data.rect_h), 32'(want.rect_h));
                check_field("fill_color", 32'(out_data.fill_color), 32'(want.fill_color));
                check_field("frame_number", 32'(out_data.frame_number),
                            32'(want.frame_number));
                check_field("frame_base", 32'(out_data.frame_base), 32'(want.frame_base));
                check_field("last", 32'(out_data.last), 32'(want.last));
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        src_idle_pct  = 12;
        rcv_stall_pct = 55;
        test_ignored_items();
        test_keyed_scaled_frame();
        test_frame_timing();
        test_dimension_clamps();
        test_random_animation();
        wait_drained();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sprite_frame_animator.f
+incdir+src
src/sfa_pkg.sv
src/sfa_ctrl.sv
src/sfa_dp.sv
src/sprite_frame_animator.sv
tb/tb_sprite_frame_animator.sv
